// ===== rtl/sellmv_pkg.sv =====
// Shared types, widths and codes of the sliced-ELLPACK matrix-vector block.
`timescale 1ns / 1ps
package sellmv_pkg;

  localparam int unsigned COL_W = 12;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned ROW_W = 16;
  localparam int unsigned CNT_W = 17;
  localparam int unsigned ACC_W = 64;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned X_DEPTH_DEF = 4096;
  localparam int unsigned MAX_ROWS_DEF = 65536;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW = 2;

  // opcode field
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_ENTRY = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd2;

  localparam logic [VAL_W-1:0] ALPHA_RST = 32'h0001_0000;
  localparam logic [CNT_W-1:0] ROWS_RST = 17'h1_0000;

  typedef struct packed {
    logic [VAL_W-1:0] alpha;
    logic [VAL_W-1:0] beta;
    logic [CNT_W-1:0] row_count;
  } cfg_t;

  // one matrix slot handed from the front to the back
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [VAL_W-1:0] xval;
    logic             skip;
    logic             row_end;
    logic [VAL_W-1:0] y_old;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_FIN_MUL,
    ST_FIN_ADD,
    ST_FIN_OUT
  } back_state_e;

endpackage

// ===== rtl/sellmv_in_if.sv =====
// Input channel: x loads and matrix slots.
`timescale 1ns / 1ps
interface sellmv_in_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [sellmv_pkg::COL_W-1:0] column;
  logic [sellmv_pkg::VAL_W-1:0] operand_value;
  logic                         pad_entry;
  logic                         row_end;
  logic [sellmv_pkg::VAL_W-1:0] y_old;

  modport source (
    output valid, opcode, column, operand_value, pad_entry, row_end, y_old,
    input  ready
  );
  modport sink (
    input  valid, opcode, column, operand_value, pad_entry, row_end, y_old,
    output ready
  );
endinterface

// ===== rtl/sellmv_out_if.sv =====
// Output channel: finished row results.
`timescale 1ns / 1ps
interface sellmv_out_if;
  logic                         valid;
  logic                         ready;
  logic [sellmv_pkg::ROW_W-1:0] row_number;
  logic [sellmv_pkg::VAL_W-1:0] y_value;

  modport source (
    output valid, row_number, y_value,
    input  ready
  );
  modport sink (
    input  valid, row_number, y_value,
    output ready
  );
endinterface

// ===== rtl/sellmv_front.sv =====
// Front end: takes input words, owns the x memory, forwards matrix slots.
`timescale 1ns / 1ps
module sellmv_front #(
  parameter int unsigned X_DEPTH = sellmv_pkg::X_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  sellmv_in_if.sink           in_i,
  output logic                push_o,
  output sellmv_pkg::entry_t  entry_o,
  input  logic                fifo_ready_i
);

  localparam int unsigned AW = (X_DEPTH > 1) ? $clog2(X_DEPTH) : 1;

  logic [sellmv_pkg::VAL_W-1:0] x_mem [X_DEPTH];
  logic [sellmv_pkg::VAL_W-1:0] rd_q;

  logic                         stg_v_q, stg_v_d;
  logic [sellmv_pkg::VAL_W-1:0] stg_value_q;
  logic                         stg_skip_q;
  logic                         stg_end_q;
  logic [sellmv_pkg::VAL_W-1:0] stg_yold_q;

  logic [31:0]   col_ext;
  logic          in_range;
  logic [AW-1:0] addr;
  logic          accept;
  logic          acc_load;
  logic          acc_entry;

  assign col_ext  = 32'(in_i.column);
  assign in_range = col_ext < 32'(X_DEPTH);
  assign addr     = col_ext[AW-1:0];

  // stage slot frees up the cycle it drains into the queue
  assign in_i.ready = !stg_v_q || fifo_ready_i;
  assign accept     = in_i.valid && in_i.ready;
  assign acc_load   = accept && (in_i.opcode == sellmv_pkg::OP_LOAD);
  assign acc_entry  = accept && (in_i.opcode == sellmv_pkg::OP_ENTRY);
  assign push_o     = stg_v_q && fifo_ready_i;

  always_comb begin
    stg_v_d = stg_v_q;
    if (acc_entry) begin
      stg_v_d = 1'b1;
    end else if (push_o) begin
      stg_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q <= 1'b0;
    end else begin
      stg_v_q <= stg_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_load && in_range) begin
      x_mem[addr] <= in_i.operand_value;
    end
    if (acc_entry && in_range) begin
      rd_q <= x_mem[addr];
    end
  end

  // out-of-range column is marked skip, so it adds nothing, same as padding
  always_ff @(posedge clk_i) begin
    if (acc_entry) begin
      stg_value_q <= in_i.operand_value;
      stg_skip_q  <= in_i.pad_entry || !in_range;
      stg_end_q   <= in_i.row_end;
      stg_yold_q  <= in_i.y_old;
    end
  end

  always_comb begin
    entry_o.value   = stg_value_q;
    entry_o.xval    = rd_q;
    entry_o.skip    = stg_skip_q;
    entry_o.row_end = stg_end_q;
    entry_o.y_old   = stg_yold_q;
  end

endmodule

// ===== rtl/sellmv_fifo.sv =====
// Short slot queue between front and back.
`timescale 1ns / 1ps
module sellmv_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sellmv_pkg::entry_t entry_i,
  output logic               ready_o,
  output logic               valid_o,
  output sellmv_pkg::entry_t head_o,
  input  logic               pop_i
);

  localparam int unsigned CW = sellmv_pkg::FIFO_AW + 1;

  sellmv_pkg::entry_t mem_q [sellmv_pkg::FIFO_DEPTH];

  logic [sellmv_pkg::FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [sellmv_pkg::FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]                  cnt_q, cnt_d;
  logic                           do_push;
  logic                           do_pop;

  assign ready_o = cnt_q != CW'(sellmv_pkg::FIFO_DEPTH);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== rtl/sellmv_back.sv =====
// Back end: multiply-accumulate loop, row finish and saturation, result register.
`timescale 1ns / 1ps
module sellmv_back #(
  parameter int unsigned MAX_ROWS = sellmv_pkg::MAX_ROWS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sellmv_pkg::cfg_t   cfg_i,
  input  logic               head_valid_i,
  input  sellmv_pkg::entry_t head_i,
  output logic               pop_o,
  sellmv_out_if.source       out_o
);

  localparam int unsigned VW = sellmv_pkg::VAL_W;
  localparam int unsigned AW = sellmv_pkg::ACC_W;
  localparam int unsigned TW = AW + VW;  // exact Q48.48 total

  sellmv_pkg::back_state_e state_q, state_d;

  logic signed [AW-1:0] prod_q;
  logic                 skip_q;
  logic                 end_q;
  logic [VW-1:0]        yold_q;

  logic [AW-1:0]                  row_sum_q, row_sum_d;
  logic [sellmv_pkg::CNT_W-1:0]   row_cnt_q, row_cnt_d;

  logic signed [AW:0]   pp_lo_q;   // low sum half (unsigned) times alpha
  logic signed [AW-1:0] pp_hi_q;   // high sum half (signed) times alpha
  logic signed [AW-1:0] bp_q;      // beta times y_old
  logic [TW-1:0]        total_q;

  logic                         out_v_q, out_v_d;
  logic [sellmv_pkg::ROW_W-1:0] out_row_q;
  logic [VW-1:0]                out_y_q;

  logic          acc_en, fin_mul, fin_add, out_load;
  logic          emit;
  logic          out_free;
  logic [AW-1:0] sum;
  logic [AW-1:0] shifted;
  logic [VW-1:0] sat;

  assign emit = (row_cnt_q < cfg_i.row_count) && (32'(row_cnt_q) < 32'(MAX_ROWS));
  assign out_free = !out_v_q || out_o.ready;
  assign sum = row_sum_q + (skip_q ? '0 : prod_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sellmv_pkg::ST_IDLE: begin
        if (head_valid_i) begin
          state_d = sellmv_pkg::ST_ACC;
        end
      end
      sellmv_pkg::ST_ACC: begin
        state_d = (end_q && emit) ? sellmv_pkg::ST_FIN_MUL : sellmv_pkg::ST_IDLE;
      end
      sellmv_pkg::ST_FIN_MUL: state_d = sellmv_pkg::ST_FIN_ADD;
      sellmv_pkg::ST_FIN_ADD: state_d = sellmv_pkg::ST_FIN_OUT;
      sellmv_pkg::ST_FIN_OUT: begin
        if (out_free) begin
          state_d = sellmv_pkg::ST_IDLE;
        end
      end
      default: state_d = sellmv_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop_o    = 1'b0;
    acc_en   = 1'b0;
    fin_mul  = 1'b0;
    fin_add  = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      sellmv_pkg::ST_IDLE:    pop_o    = head_valid_i;
      sellmv_pkg::ST_ACC:     acc_en   = 1'b1;
      sellmv_pkg::ST_FIN_MUL: fin_mul  = 1'b1;
      sellmv_pkg::ST_FIN_ADD: fin_add  = 1'b1;
      sellmv_pkg::ST_FIN_OUT: out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    row_sum_d = row_sum_q;
    row_cnt_d = row_cnt_q;
    if (acc_en) begin
      if (end_q && !emit) begin
        // silent row: drop the sum, still advance
        row_sum_d = '0;
        if (row_cnt_q != '1) begin
          row_cnt_d = row_cnt_q + 1'b1;
        end
      end else begin
        row_sum_d = sum;
      end
    end else if (out_load) begin
      row_sum_d = '0;
      if (row_cnt_q != '1) begin
        row_cnt_d = row_cnt_q + 1'b1;
      end
    end
  end

  always_comb begin
    out_v_d = out_v_q;
    if (out_load) begin
      out_v_d = 1'b1;
    end else if (out_o.ready) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sellmv_pkg::ST_IDLE;
      row_sum_q <= '0;
      row_cnt_q <= '0;
      out_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      row_sum_q <= row_sum_d;
      row_cnt_q <= row_cnt_d;
      out_v_q   <= out_v_d;
    end
  end

  // arithmetic shift by 32 floors; saturate when bits 63..31 disagree
  assign shifted = total_q[TW-1:VW];
  always_comb begin
    if (shifted[AW-1:VW-1] == '0 || shifted[AW-1:VW-1] == '1) begin
      sat = shifted[VW-1:0];
    end else if (shifted[AW-1]) begin
      sat = {1'b1, {(VW-1){1'b0}}};
    end else begin
      sat = {1'b0, {(VW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      prod_q <= $signed(head_i.value) * $signed(head_i.xval);
      skip_q <= head_i.skip;
      end_q  <= head_i.row_end;
      yold_q <= head_i.y_old;
    end
    if (fin_mul) begin
      pp_lo_q <= $signed({1'b0, row_sum_q[VW-1:0]}) * $signed(cfg_i.alpha);
      pp_hi_q <= $signed(row_sum_q[AW-1:VW]) * $signed(cfg_i.alpha);
      bp_q    <= $signed(cfg_i.beta) * $signed(yold_q);
    end
    if (fin_add) begin
      total_q <= {pp_hi_q, {VW{1'b0}}}
               + {{(TW-AW-1){pp_lo_q[AW]}}, pp_lo_q}
               + {{(TW-AW-16){bp_q[AW-1]}}, bp_q, 16'd0};
    end
    if (out_load) begin
      out_row_q <= row_cnt_q[sellmv_pkg::ROW_W-1:0];
      out_y_q   <= sat;
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.row_number = out_row_q;
  assign out_o.y_value    = out_y_q;

endmodule

// ===== rtl/sell_sparse_matvec.sv =====
// Top level of the sliced-ELLPACK y = alpha*A*x + beta*y block.
// Input channel in_i: opcode 0 writes operand_value into x[column]; opcode 1 is
// a matrix slot (value, pad flag, row-end flag, old y of the row).
// Output channel out_o: one word per finished row, row_number and y_value
// (Q16.16, floored and saturated). Rows at or past row_count give no word.
// Config port: cfg_we_i/cfg_idx_i/cfg_data_i write alpha (0), beta (1),
// row_count (2); other indexes are ignored. Write only while idle.
// A load is written at the front. A matrix slot is popped and multiplied in
// the back end's IDLE state, then added into the 64-bit row sum in ACC; that
// loop sets the sustained rate, with no new slot taken before it finishes. A
// row end that emits then runs FIN_MUL, FIN_ADD and FIN_OUT (finish multiplies,
// Q48.48 add, saturate into the result register) before the word is valid.
// A 4-deep slot queue sits between front and back.
// Reset: queue and result register empty, row sum and row counter zero,
// alpha = 1.0, beta = 0, row_count = 65536. The x memory is not cleared.
// Receiver stall: the result word is held; the back keeps accumulating up to
// the next emitting row end, then the queue fills and in_i.ready drops.
`timescale 1ns / 1ps
module sell_sparse_matvec #(
  parameter int unsigned X_DEPTH  = sellmv_pkg::X_DEPTH_DEF,
  parameter int unsigned MAX_ROWS = sellmv_pkg::MAX_ROWS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  sellmv_in_if.sink                        in_i,
  sellmv_out_if.source                     out_o,
  input  logic                             cfg_we_i,
  input  logic [sellmv_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sellmv_pkg::VAL_W-1:0]     cfg_data_i
);

  sellmv_pkg::cfg_t   cfg_q, cfg_d;
  sellmv_pkg::entry_t push_entry;
  sellmv_pkg::entry_t head;
  logic               push;
  logic               fifo_ready;
  logic               head_valid;
  logic               pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sellmv_pkg::CFG_ALPHA: cfg_d.alpha = cfg_data_i;
        sellmv_pkg::CFG_BETA:  cfg_d.beta = cfg_data_i;
        sellmv_pkg::CFG_ROWS:  cfg_d.row_count = cfg_data_i[sellmv_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alpha     <= sellmv_pkg::ALPHA_RST;
      cfg_q.beta      <= '0;
      cfg_q.row_count <= sellmv_pkg::ROWS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sellmv_front #(
    .X_DEPTH (X_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_o       (push),
    .entry_o      (push_entry),
    .fifo_ready_i (fifo_ready)
  );

  sellmv_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .ready_o (fifo_ready),
    .valid_o (head_valid),
    .head_o  (head),
    .pop_i   (pop)
  );

  sellmv_back #(
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

// ===== tb/sell_sparse_matvec_tb.sv =====
// Self-checking testbench for the sliced-ELLPACK y = alpha*A*x + beta*y block.
`timescale 1ns / 1ps
module sell_sparse_matvec_tb;

  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned SETTLE_CYCLES = 40;
  // no register behind it
  localparam logic [sellmv_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam logic signed [127:0] Y_MAX = 128'sh7FFF_FFFF;
  localparam logic signed [127:0] Y_MIN = -128'sh8000_0000;

  typedef struct packed {
    logic                         opcode;
    logic [sellmv_pkg::COL_W-1:0] column;
    logic [sellmv_pkg::VAL_W-1:0] operand_value;
    logic                         pad_entry;
    logic                         row_end;
    logic [sellmv_pkg::VAL_W-1:0] y_old;
  } slot_t;

  typedef struct packed {
    logic [sellmv_pkg::ROW_W-1:0] row_number;
    logic [sellmv_pkg::VAL_W-1:0] y_value;
  } row_word_t;

  typedef struct packed {
    slot_t                        slot;
    logic                         typed;
    logic [sellmv_pkg::ROW_W-1:0] exp_row;
    logic [sellmv_pkg::VAL_W-1:0] exp_y;
  } dir_row_t;

  // x[0]=1.0, x[4095]=max, x[0xAAA]=min, x[0x555]=2.0; alpha 1.0, beta 0
  localparam dir_row_t DIRECTED [20] = '{
    '{'{sellmv_pkg::OP_LOAD,  12'h000, 32'h0001_0000, 1'b0, 1'b0, 32'h0000_0000},
      1'b0, 16'd0, 32'h0},
    '{'{sellmv_pkg::OP_LOAD,  12'hFFF, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
      1'b0, 16'd0, 32'h0},
    '{'{sellmv_pkg::OP_LOAD,  12'hAAA, 32'h8000_0000, 1'b0, 1'b0, 32'h0000_0000},
      1'b0, 16'd0, 32'h0},
    '{'{sellmv_pkg::OP_LOAD,  12'h555, 32'h0002_0000, 1'b0, 1'b0, 32'h0000_0000},
      1'b0, 16'd0, 32'h0},
    '{'{sellmv_pkg::OP_ENTRY, 12'h000, 32'h0003_0000, 1'b0, 1'b1, 32'h1234_5678},
      1'b1, 16'd0, 32'h0003_0000},
    // padding slot that ends the row: sum stays zero, y_old ignored
    '{'{sellmv_pkg::OP_ENTRY, 12'hAAA, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},
      1'b1, 16'd1, 32'h0000_0000},
    '{'{sellmv_pkg::OP_ENTRY, 12'hFFF, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0000_0000},
      1'b0, 16'd0, 32'h0},
    '{'{sellmv_pkg::OP_ENTRY, 12'hFFF, 32'h7FFF_FFFF, 1'b0, 1'b1, 32'h0000_0000},
      1'b1, 16'd2, 32'h7FFF_FFFF},
    '{'{sellmv_pkg::OP_ENTRY, 12'hAAA, 32'h8000_0000, 1'b0, 1'b1, 32'h0000_0000},
      1'b1, 16'd3, 32'h7FFF_FFFF},
    '{'{sellmv_pkg::OP_ENTRY, 12'hAAA, 32'h7FFF_FFFF, 1'b0, 1'b1, 32'h0000_0000},
      1'b1, 16'd4, 32'h8000_0000},
    // four products of 2^62 wrap the accumulator back to zero
    '{'{sellmv_pkg::OP_ENTRY, 12'hAAA, 32'h8000_0000, 1'b0, 1'b0, 32'h0000_0000},
      1'b0, 16'd0, 32'h0},
    '{'{sellmv_pkg::OP_ENTRY, 12'hAAA, 32'h8000_0000, 1'b0, 1'b0, 32'h0000_0000},
      1'b0, 16'd0, 32'h0},
    '{'{sellmv_pkg::OP_ENTRY, 12'hAAA, 32'h8000_0000, 1'b0, 1'b0, 32'h0000_0000},
      1'b0, 16'd0, 32'h0},
    '{'{sellmv_pkg::OP_ENTRY, 12'hAAA, 32'h8000_0000, 1'b0, 1'b1, 32'h0000_0000},
      1'b1, 16'd5, 32'h0000_0000},
    '{'{sellmv_pkg::OP_ENTRY, 12'h555, 32'hFFFF_0000, 1'b0, 1'b0, 32'h0000_0000},
      1'b0, 16'd0, 32'h0},
    '{'{sellmv_pkg::OP_ENTRY, 12'h555, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h0000_0000},
      1'b1, 16'd6, 32'hFFFE_0000},
    // load mid-stream with pad/end set: no row end
    '{'{sellmv_pkg::OP_LOAD,  12'h000, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h8000_0000},
      1'b0, 16'd0, 32'h0},
    '{'{sellmv_pkg::OP_ENTRY, 12'h000, 32'h0001_0000, 1'b0, 1'b1, 32'h0000_0000},
      1'b1, 16'd7, 32'hFFFF_FFFF},
    // tiny negative sum floors to -1 lsb
    '{'{sellmv_pkg::OP_ENTRY, 12'h000, 32'h0000_0001, 1'b0, 1'b1, 32'h0000_0000},
      1'b1, 16'd8, 32'hFFFF_FFFF},
    '{'{sellmv_pkg::OP_ENTRY, 12'h555, 32'h0000_8000, 1'b0, 1'b1, 32'h8000_0000},
      1'b1, 16'd9, 32'h0001_0000}
  };

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             cfg_we_i;
  logic [sellmv_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [sellmv_pkg::VAL_W-1:0]     cfg_data_i;

  sellmv_in_if  slot_if ();
  sellmv_out_if row_if ();

  sell_sparse_matvec dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (slot_if),
    .out_o      (row_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // shadow of the block state
  logic [sellmv_pkg::VAL_W-1:0]        x_mem [sellmv_pkg::X_DEPTH_DEF];
  bit                                  col_written [sellmv_pkg::X_DEPTH_DEF];
  int unsigned                         written_cols [$];
  logic signed [sellmv_pkg::ACC_W-1:0] row_acc;
  logic [sellmv_pkg::CNT_W-1:0]        row_idx;
  logic [sellmv_pkg::VAL_W-1:0]        gain_alpha;
  logic [sellmv_pkg::VAL_W-1:0]        gain_beta;
  logic [sellmv_pkg::CNT_W-1:0]        rows_limit;

  row_word_t pending_rows [$];
  int        fail_cnt = 0;
  int        burst_left;
  int        rx_hold;
  int        rx_free;
  int        cycle_cnt;

  always #5 clk_i = ~clk_i;

  function automatic logic [sellmv_pkg::VAL_W-1:0] small_q16();
    logic [31:0] r;
    r = $urandom;
    return {{13{r[18]}}, r[18:0]};  // within +-4.0
  endfunction

  function automatic logic [sellmv_pkg::VAL_W-1:0] pick_q16();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3, 4: return $urandom;
      default: return small_q16();
    endcase
  endfunction

  function automatic void predict_slot(input slot_t s, output logic emit, output row_word_t r);
    logic signed [sellmv_pkg::ACC_W-1:0] prod;
    logic signed [127:0]                 a_w;
    logic signed [127:0]                 sum_w;
    logic signed [127:0]                 b_w;
    logic signed [127:0]                 y_w;
    logic signed [127:0]                 total;
    emit = 1'b0;
    r = '0;
    if (s.opcode == sellmv_pkg::OP_LOAD) begin
      x_mem[s.column] = s.operand_value;
      if (!col_written[s.column]) begin
        col_written[s.column] = 1'b1;
        written_cols.push_back(s.column);
      end
      return;
    end
    if (!s.pad_entry) begin
      prod = $signed(s.operand_value) * $signed(x_mem[s.column]);
      row_acc = row_acc + prod;
    end
    if (!s.row_end) return;
    if (row_idx < rows_limit &&
        row_idx < sellmv_pkg::CNT_W'(sellmv_pkg::MAX_ROWS_DEF)) begin
      a_w = $signed(gain_alpha);
      sum_w = row_acc;
      b_w = $signed(gain_beta);
      y_w = $signed(s.y_old);
      // Q48.48 sum, floored back to Q16.16
      total = (a_w * sum_w + ((b_w * y_w) <<< 16)) >>> 32;
      emit = 1'b1;
      r.row_number = row_idx[sellmv_pkg::ROW_W-1:0];
      if (total > Y_MAX) r.y_value = 32'h7FFF_FFFF;
      else if (total < Y_MIN) r.y_value = 32'h8000_0000;
      else r.y_value = total[sellmv_pkg::VAL_W-1:0];
    end
    row_acc = '0;
    if (row_idx != '1) row_idx = row_idx + 1'b1;
  endfunction

  task automatic send_slot(input slot_t s);
    if (burst_left == 0) begin
      slot_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? 150 : $urandom_range(1, 12);
    end
    slot_if.valid <= 1'b1;
    slot_if.opcode <= s.opcode;
    slot_if.column <= s.column;
    slot_if.operand_value <= s.operand_value;
    slot_if.pad_entry <= s.pad_entry;
    slot_if.row_end <= s.row_end;
    slot_if.y_old <= s.y_old;
    do @(posedge clk_i); while (!slot_if.ready);
    burst_left--;
  endtask

  // hold off the sender until every row word is back and the back end is quiet
  task automatic drain();
    slot_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_gains(input logic [sellmv_pkg::VAL_W-1:0] alpha,
                               input logic [sellmv_pkg::VAL_W-1:0] beta,
                               input logic [sellmv_pkg::CNT_W-1:0] rows,
                               input bit poke_spare);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= sellmv_pkg::CFG_ALPHA;
    cfg_data_i <= alpha;
    @(posedge clk_i);
    cfg_idx_i <= sellmv_pkg::CFG_BETA;
    cfg_data_i <= beta;
    @(posedge clk_i);
    cfg_idx_i <= sellmv_pkg::CFG_ROWS;
    cfg_data_i <= sellmv_pkg::VAL_W'(rows);
    @(posedge clk_i);
    if (poke_spare) begin
      cfg_idx_i <= CFG_SPARE;
      cfg_data_i <= $urandom;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    gain_alpha = alpha;
    gain_beta = beta;
    rows_limit = rows;
    @(posedge clk_i);
  endtask

  task automatic run_random(input int n_items, input bit mid_drain);
    slot_t     s;
    logic      emit;
    row_word_t r;
    for (int i = 0; i < n_items; i++) begin
      s.operand_value = pick_q16();
      s.y_old = pick_q16();
      s.pad_entry = ($urandom_range(0, 4) == 0);
      s.row_end = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 7) == 0) begin
        s.opcode = sellmv_pkg::OP_LOAD;
        case ($urandom_range(0, 5))
          0: s.column = '0;
          1: s.column = '1;
          default: s.column = sellmv_pkg::COL_W'($urandom);
        endcase
      end else begin
        // entries only touch x words already loaded
        s.opcode = sellmv_pkg::OP_ENTRY;
        s.column = sellmv_pkg::COL_W'(written_cols[$urandom_range(0, written_cols.size() - 1)]);
      end
      send_slot(s);
      predict_slot(s, emit, r);
      if (emit) pending_rows.push_back(r);
      if (mid_drain && i == n_items / 2) drain();
    end
  endtask

  // receiver: long stalls, free-running stretches and random drops
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      row_if.ready <= 1'b0;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      row_if.ready <= 1'b0;
    end else if (rx_free != 0) begin
      rx_free <= rx_free - 1;
      row_if.ready <= 1'b1;
    end else begin
      case ($urandom_range(0, 19))
        0: begin
          rx_hold <= $urandom_range(5, 40);
          row_if.ready <= 1'b0;
        end
        1: begin
          rx_free <= $urandom_range(50, 300);
          row_if.ready <= 1'b1;
        end
        2, 3, 4, 5, 6, 7: row_if.ready <= 1'b0;
        default: row_if.ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk_i) begin : row_check
    row_word_t want;
    if (rst_ni && row_if.valid && row_if.ready) begin
      if (pending_rows.size() == 0) begin
        $error("unexpected row word: row_number %0d y_value %h",
               row_if.row_number, row_if.y_value);
        fail_cnt++;
      end else begin
        want = pending_rows.pop_front();
        if (row_if.row_number !== want.row_number) begin
          $error("row_number: expected %0d, actual %0d", want.row_number, row_if.row_number);
          fail_cnt++;
        end
        if (row_if.y_value !== want.y_value) begin
          $error("y_value: expected %h, actual %h", want.y_value, row_if.y_value);
          fail_cnt++;
        end
      end
    end
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    logic                         emit;
    row_word_t                    r;
    logic [sellmv_pkg::VAL_W-1:0] alpha_v;
    logic [sellmv_pkg::VAL_W-1:0] beta_v;
    logic [sellmv_pkg::CNT_W-1:0] rows_v;
    int                           n_items;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = sellmv_pkg::CFG_ALPHA;
    cfg_data_i = '0;
    slot_if.valid = 1'b0;
    slot_if.opcode = sellmv_pkg::OP_LOAD;
    slot_if.column = '0;
    slot_if.operand_value = '0;
    slot_if.pad_entry = 1'b0;
    slot_if.row_end = 1'b0;
    slot_if.y_old = '0;
    burst_left = 0;
    row_acc = '0;
    row_idx = '0;
    gain_alpha = sellmv_pkg::ALPHA_RST;
    gain_beta = '0;
    rows_limit = sellmv_pkg::ROWS_RST;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) begin
      send_slot(DIRECTED[i].slot);
      predict_slot(DIRECTED[i].slot, emit, r);
      if (DIRECTED[i].typed) pending_rows.push_back({DIRECTED[i].exp_row, DIRECTED[i].exp_y});
      else if (emit) pending_rows.push_back(r);
    end
    drain();

    for (int p = 1; p <= 8; p++) begin
      rows_v = sellmv_pkg::ROWS_RST;
      case (p)
        1: begin
          alpha_v = small_q16();
          beta_v = 32'h0000_8000;
          n_items = 300;
        end
        2: begin
          alpha_v = 32'h7FFF_FFFF;
          beta_v = 32'h8000_0000;
          n_items = 200;
        end
        3: begin
          alpha_v = 32'h8000_0000;
          beta_v = 32'h7FFF_FFFF;
          n_items = 200;
        end
        4: begin
          alpha_v = '0;
          beta_v = $urandom;
          n_items = 150;
        end
        5: begin
          alpha_v = $urandom;
          beta_v = $urandom;
          n_items = 250;
        end
        6: begin
          // a few rows still count, the rest are past row_count
          alpha_v = 32'h0001_0000;
          beta_v = 32'hFFFF_0000;
          rows_v = row_idx + sellmv_pkg::CNT_W'(5);
          n_items = 150;
        end
        7: begin
          alpha_v = small_q16();
          beta_v = small_q16();
          rows_v = 17'd1;
          n_items = 100;
        end
        default: begin
          alpha_v = small_q16();
          beta_v = small_q16();
          n_items = 600;
        end
      endcase
      program_gains(alpha_v, beta_v, rows_v, p == 2);
      run_random(n_items, p == 5);
      drain();
    end

    if (fail_cnt == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sellmv_pkg.sv
rtl/sellmv_in_if.sv
rtl/sellmv_out_if.sv
rtl/sellmv_front.sv
rtl/sellmv_fifo.sv
rtl/sellmv_back.sv
rtl/sell_sparse_matvec.sv
tb/sell_sparse_matvec_tb.sv
